### design/lfp_pkg.sv
// ---------------------------------------------------------------------------
// lfp_pkg : shared types, constants and CRC helper for the lidar frame parser
// Frame layout offsets, angle arithmetic limits and the RAM write port struct.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfp_pkg;

    localparam int MEASURE_FRAME_BYTES = 47;
    localparam int SHORT_FRAME_BYTES   = 12;
    localparam int PTS_PER_FRAME       = 12;
    localparam int FRAME_ADDR_W        = $clog2(MEASURE_FRAME_BYTES);
    localparam int COUNT_W             = 6;

    localparam logic [7:0] HDR_BYTE     = 8'h54;
    localparam logic [7:0] KIND_MEASURE = 8'h2C;
    localparam logic [7:0] KIND_HEALTH  = 8'hE0;
    localparam logic [7:0] KIND_INFO    = 8'h0F;
    localparam logic [7:0] CRC_POLY     = 8'h4D;

    // byte offsets inside a measurement frame
    localparam logic [FRAME_ADDR_W-1:0] ADDR_HDR      = FRAME_ADDR_W'(0);
    localparam logic [FRAME_ADDR_W-1:0] ADDR_KIND     = FRAME_ADDR_W'(1);
    localparam logic [FRAME_ADDR_W-1:0] ADDR_START_LO = FRAME_ADDR_W'(4);
    localparam logic [FRAME_ADDR_W-1:0] ADDR_START_HI = FRAME_ADDR_W'(5);
    localparam logic [FRAME_ADDR_W-1:0] ADDR_FIRST_PT = FRAME_ADDR_W'(6);
    localparam logic [FRAME_ADDR_W-1:0] ADDR_END_LO   = FRAME_ADDR_W'(6 + 3 * PTS_PER_FRAME);
    localparam logic [FRAME_ADDR_W-1:0] ADDR_END_HI   = FRAME_ADDR_W'(7 + 3 * PTS_PER_FRAME);
    localparam logic [FRAME_ADDR_W-1:0] ADDR_CRC      = FRAME_ADDR_W'(MEASURE_FRAME_BYTES - 1);
    localparam logic [FRAME_ADDR_W-1:0] PT_STRIDE     = FRAME_ADDR_W'(3);

    // angle arithmetic, 1/1200 degree units
    localparam int ANGLE_W = 19;
    localparam int ACC_W   = 21;
    localparam int SPAN_W  = 18;

    localparam logic signed [ACC_W-1:0]  HALF_TURN     = 21'sd216000;
    localparam logic signed [ACC_W-1:0]  NEG_HALF_TURN = -21'sd216000;
    localparam logic signed [ACC_W-1:0]  FULL_TURN     = 21'sd432000;
    localparam logic signed [SPAN_W-1:0] SPAN_FIX      = 18'sd36000;

    typedef struct packed {
        logic                    en;
        logic [FRAME_ADDR_W-1:0] addr;
        logic [7:0]              data;
    } t_mem_wr;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### design/lfp_parser.sv
// ---------------------------------------------------------------------------
// lfp_parser : byte-level frame hunter and CRC checker
// Tracks header/kind/body phases, writes measurement frame bytes to the frame RAM and
// flags a measurement frame whose checksum matches.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfp_parser #(
    parameter int SHORT_FRAME_BYTES = lfp_pkg::SHORT_FRAME_BYTES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_wr_data,
    input  logic            i_accept,
    input  logic [7:0]      i_rx_byte,
    output lfp_pkg::t_mem_wr o_wr,
    output logic            o_frame_ok
);

    typedef enum logic [3:0] {
        PS_HUNT    = 4'b0001,
        PS_KIND    = 4'b0010,
        PS_MEASURE = 4'b0100,
        PS_SHORT   = 4'b1000
    } t_parse_state;

    localparam logic [lfp_pkg::COUNT_W-1:0] SHORT_LEN =
        lfp_pkg::COUNT_W'(SHORT_FRAME_BYTES);
    localparam logic [lfp_pkg::COUNT_W-1:0] LAST_POS =
        lfp_pkg::COUNT_W'(lfp_pkg::MEASURE_FRAME_BYTES - 1);

    t_parse_state                 r_phase, n_phase;
    logic [lfp_pkg::COUNT_W-1:0]  r_cnt, n_cnt;
    logic [7:0]                   r_crc, n_crc;
    logic                         r_rx_enable;
    logic [lfp_pkg::COUNT_W-1:0]  w_cnt_inc;

    assign w_cnt_inc = r_cnt + lfp_pkg::COUNT_W'(1);

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_crc       = r_crc;
        o_wr.en     = 1'b0;
        o_wr.addr   = lfp_pkg::FRAME_ADDR_W'(r_cnt);
        o_wr.data   = i_rx_byte;
        o_frame_ok  = 1'b0;
        if (i_accept && r_rx_enable) begin
            unique case (r_phase)
                PS_HUNT: begin
                    if (i_rx_byte == lfp_pkg::HDR_BYTE) begin
                        o_wr.en   = 1'b1;
                        o_wr.addr = lfp_pkg::ADDR_HDR;
                        n_crc     = lfp_pkg::crc8_update(8'h00, i_rx_byte);
                        n_cnt     = lfp_pkg::COUNT_W'(1);
                        n_phase   = PS_KIND;
                    end
                end
                PS_KIND: begin
                    if (i_rx_byte == lfp_pkg::KIND_MEASURE) begin
                        o_wr.en   = 1'b1;
                        o_wr.addr = lfp_pkg::ADDR_KIND;
                        n_crc     = lfp_pkg::crc8_update(r_crc, i_rx_byte);
                        n_cnt     = lfp_pkg::COUNT_W'(2);
                        n_phase   = PS_MEASURE;
                    end else if (i_rx_byte == lfp_pkg::KIND_HEALTH ||
                                 i_rx_byte == lfp_pkg::KIND_INFO) begin
                        n_cnt     = lfp_pkg::COUNT_W'(2);
                        n_phase   = PS_SHORT;
                    end else begin
                        n_phase   = PS_HUNT;
                    end
                end
                PS_MEASURE: begin
                    o_wr.en = 1'b1;
                    if (r_cnt >= LAST_POS) begin
                        // checksum byte closes the frame
                        o_wr.addr  = lfp_pkg::ADDR_CRC;
                        o_frame_ok = (r_crc == i_rx_byte);
                        n_cnt      = '0;
                        n_phase    = PS_HUNT;
                    end else begin
                        n_crc = lfp_pkg::crc8_update(r_crc, i_rx_byte);
                        n_cnt = w_cnt_inc;
                    end
                end
                PS_SHORT: begin
                    if (w_cnt_inc >= SHORT_LEN) begin
                        n_cnt   = '0;
                        n_phase = PS_HUNT;
                    end else begin
                        n_cnt   = w_cnt_inc;
                    end
                end
                default: begin
                    n_phase = PS_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PS_HUNT;
            r_cnt       <= '0;
            r_crc       <= '0;
            r_rx_enable <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_crc   <= n_crc;
            if (i_cfg_wr_en) begin
                r_rx_enable <= i_cfg_wr_data;
            end
        end
    end

endmodule

### design/lfp_frame_ram.sv
// ---------------------------------------------------------------------------
// lfp_frame_ram : frame byte store
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfp_frame_ram (
    input  logic                             i_clk,
    input  lfp_pkg::t_mem_wr                 i_wr,
    input  logic [lfp_pkg::FRAME_ADDR_W-1:0] i_rd_addr,
    output logic [7:0]                       o_rd_data
);

    logic [7:0] r_mem [lfp_pkg::MEASURE_FRAME_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/lfp_decoder.sv
// ---------------------------------------------------------------------------
// lfp_decoder : point decoder
// Reads a checked frame back from the RAM, steps the angle per point and
// presents the twelve points through an output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfp_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_frame_ok,
    output logic                             o_idle,
    output logic [lfp_pkg::FRAME_ADDR_W-1:0] o_rd_addr,
    input  logic [7:0]                       i_rd_data,
    output logic                             o_pt_valid,
    input  logic                             i_pt_ready,
    output logic [15:0]                      o_distance_mm,
    output logic [7:0]                       o_intensity,
    output logic signed [18:0]               o_angle,
    output logic [3:0]                       o_point_number,
    output logic                             o_last_of_frame,
    output logic                             o_scan_complete
);

    localparam int AW = lfp_pkg::FRAME_ADDR_W;

    typedef enum logic [5:0] {
        DS_IDLE = 6'b000001,
        DS_HDR  = 6'b000010,
        DS_SPAN = 6'b000100,
        DS_WRAP = 6'b001000,
        DS_PT   = 6'b010000,
        DS_EMIT = 6'b100000
    } t_dec_state;

    t_dec_state                        r_state, n_state;
    logic [2:0]                        r_step, n_step;
    logic [31:0]                       r_hdr, n_hdr;
    logic signed [lfp_pkg::SPAN_W-1:0] r_span, n_span;
    logic signed [lfp_pkg::ACC_W-1:0]  r_acc, n_acc;
    logic [3:0]                        r_pt, n_pt;
    logic [AW-1:0]                     r_base, n_base;
    logic [15:0]                       r_dist, n_dist;
    logic [7:0]                        r_inten, n_inten;
    logic                              r_rose, n_rose;
    logic signed [18:0]                r_prev, n_prev;

    logic                              r_out_valid, n_out_valid;
    logic [15:0]                       r_o_dist;
    logic [7:0]                        r_o_inten;
    logic signed [18:0]                r_o_angle;
    logic [3:0]                        r_o_pt;
    logic                              r_o_last;
    logic                              r_o_scan;

    logic [19:0]                       w_s12;
    logic signed [lfp_pkg::SPAN_W-1:0] w_span_raw;
    logic signed [lfp_pkg::SPAN_W-1:0] w_span_fix;
    logic signed [18:0]                w_angle;
    logic                              w_rose;
    logic                              w_last;
    logic                              w_load;

    // start angle times twelve, then its negation seeds the accumulator
    assign w_s12      = {1'b0, r_hdr[15:0], 3'b000} + {2'b00, r_hdr[15:0], 2'b00};
    assign w_span_raw = $signed({2'b00, r_hdr[31:16]}) - $signed({2'b00, r_hdr[15:0]});
    assign w_span_fix = w_span_raw + lfp_pkg::SPAN_FIX;
    assign w_angle    = r_acc[18:0];
    assign w_rose     = r_rose || (w_angle > r_prev);
    assign w_last     = (r_pt == 4'(lfp_pkg::PTS_PER_FRAME - 1));
    assign w_load     = (r_state == DS_EMIT) && (!r_out_valid || i_pt_ready);

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_hdr     = r_hdr;
        n_span    = r_span;
        n_acc     = r_acc;
        n_pt      = r_pt;
        n_base    = r_base;
        n_dist    = r_dist;
        n_inten   = r_inten;
        n_rose    = r_rose;
        n_prev    = r_prev;
        o_rd_addr = r_base + AW'(r_step[1:0]);
        unique case (r_state)
            DS_IDLE: begin
                if (i_frame_ok) begin
                    n_state = DS_HDR;
                    n_step  = '0;
                end
            end
            DS_HDR: begin
                unique case (r_step[1:0])
                    2'd0:    o_rd_addr = lfp_pkg::ADDR_START_LO;
                    2'd1:    o_rd_addr = lfp_pkg::ADDR_START_HI;
                    2'd2:    o_rd_addr = lfp_pkg::ADDR_END_LO;
                    default: o_rd_addr = lfp_pkg::ADDR_END_HI;
                endcase
                if (r_step != 3'd0) begin
                    n_hdr = {i_rd_data, r_hdr[31:8]};
                end
                if (r_step == 3'd4) begin
                    n_state = DS_SPAN;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            DS_SPAN: begin
                n_span  = w_span_raw[lfp_pkg::SPAN_W-1] ? w_span_fix : w_span_raw;
                n_acc   = -$signed({1'b0, w_s12});
                n_pt    = '0;
                n_base  = lfp_pkg::ADDR_FIRST_PT;
                n_rose  = 1'b0;
                n_state = DS_WRAP;
            end
            DS_WRAP: begin
                if (r_acc < lfp_pkg::NEG_HALF_TURN) begin
                    n_acc = r_acc + lfp_pkg::FULL_TURN;
                end else begin
                    n_step  = '0;
                    n_state = DS_PT;
                end
            end
            DS_PT: begin
                unique case (r_step[1:0])
                    2'd0: begin
                        // fold the angle of the step just taken back into range
                        priority if (r_acc >= lfp_pkg::HALF_TURN) begin
                            n_acc = r_acc - lfp_pkg::FULL_TURN;
                        end else if (r_acc < lfp_pkg::NEG_HALF_TURN) begin
                            n_acc = r_acc + lfp_pkg::FULL_TURN;
                        end
                    end
                    2'd1:    n_dist[7:0]  = i_rd_data;
                    2'd2:    n_dist[15:8] = i_rd_data;
                    default: n_inten      = i_rd_data;
                endcase
                if (r_step[1:0] == 2'd3) begin
                    n_state = DS_EMIT;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            DS_EMIT: begin
                if (w_load) begin
                    n_prev = w_angle;
                    n_rose = w_rose;
                    n_acc  = r_acc - {{(lfp_pkg::ACC_W - lfp_pkg::SPAN_W){r_span[lfp_pkg::SPAN_W-1]}},
                                      r_span};
                    n_pt   = r_pt + 4'd1;
                    n_base = r_base + lfp_pkg::PT_STRIDE;
                    n_step = '0;
                    n_state = w_last ? DS_IDLE : DS_PT;
                end
            end
            default: begin
                n_state = DS_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_pt_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= DS_IDLE;
            r_step      <= '0;
            r_prev      <= '0;
            r_rose      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_prev      <= n_prev;
            r_rose      <= n_rose;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr   <= n_hdr;
        r_span  <= n_span;
        r_acc   <= n_acc;
        r_pt    <= n_pt;
        r_base  <= n_base;
        r_dist  <= n_dist;
        r_inten <= n_inten;
        if (w_load) begin
            r_o_dist  <= r_dist;
            r_o_inten <= r_inten;
            r_o_angle <= w_angle;
            r_o_pt    <= r_pt;
            r_o_last  <= w_last;
            r_o_scan  <= w_last && w_rose;
        end
    end

    assign o_idle          = (r_state == DS_IDLE);
    assign o_pt_valid      = r_out_valid;
    assign o_distance_mm   = r_o_dist;
    assign o_intensity     = r_o_inten;
    assign o_angle         = r_o_angle;
    assign o_point_number  = r_o_pt;
    assign o_last_of_frame = r_o_last;
    assign o_scan_complete = r_o_scan;

endmodule

### design/lidar_frame_parser_point_decoder_unit.sv
// ---------------------------------------------------------------------------
// lidar_frame_parser_point_decoder_unit : lidar serial frame parser, top level
// Hunts frames in the received byte stream, checks CRC-8 and emits twelve
// decoded points per good measurement frame.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  rx       | in        | i_rx_valid / o_rx_ready    | i_rx_byte
//  pt       | out       | o_pt_valid / i_pt_ready    | distance, intensity, angle,
//           |           |                            | point number, last, scan done
//  cfg      | in        | i_cfg_wr_en (no wait)      | i_cfg_wr_data (rx enable)
//
//  One byte per cycle while no frame is being decoded.
//  After the checksum byte of a good frame the rx side stalls while the frame
//  RAM is read back: the start and end angles first, then the angle
//  accumulator set-up, then each point (three RAM reads plus emit); the
//  stall is longer if the pt side holds off ready.
//  Synchronous active-low reset; no RAM clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lidar_frame_parser_point_decoder_unit #(
    parameter int SHORT_FRAME_BYTES = lfp_pkg::SHORT_FRAME_BYTES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_pt_valid,
    input  logic               i_pt_ready,
    output logic [15:0]        o_distance_mm,
    output logic [7:0]         o_intensity,
    output logic signed [18:0] o_angle,
    output logic [3:0]         o_point_number,
    output logic               o_last_of_frame,
    output logic               o_scan_complete
);

    lfp_pkg::t_mem_wr                 w_wr;
    logic [lfp_pkg::FRAME_ADDR_W-1:0] w_rd_addr;
    logic [7:0]                       w_rd_data;
    logic                             w_frame_ok;
    logic                             w_idle;
    logic                             w_accept;

    assign o_rx_ready = w_idle;
    assign w_accept   = i_rx_valid && w_idle;

    lfp_parser #(
        .SHORT_FRAME_BYTES (SHORT_FRAME_BYTES)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (w_accept),
        .i_rx_byte     (i_rx_byte),
        .o_wr          (w_wr),
        .o_frame_ok    (w_frame_ok)
    );

    lfp_frame_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    lfp_decoder u_decoder (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frame_ok      (w_frame_ok),
        .o_idle          (w_idle),
        .o_rd_addr       (w_rd_addr),
        .i_rd_data       (w_rd_data),
        .o_pt_valid      (o_pt_valid),
        .i_pt_ready      (i_pt_ready),
        .o_distance_mm   (o_distance_mm),
        .o_intensity     (o_intensity),
        .o_angle         (o_angle),
        .o_point_number  (o_point_number),
        .o_last_of_frame (o_last_of_frame),
        .o_scan_complete (o_scan_complete)
    );

endmodule
